// ----- hdl/spi_eeprom_page_write_sequencer_unit_defines.svh -----
// Assertion macros shared by the sequencer RTL.
`ifndef SPI_EEPROM_PAGE_WRITE_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_EEPROM_PAGE_WRITE_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked while out of reset.
`define SEPW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sequencer check failed");
// Checked on every edge, reset included.
`define SEPW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sequencer check failed");
`else
`define SEPW_ASSERT(lbl, clk, rstn, prop)
`define SEPW_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hdl/spi_epw_pkg.sv -----
`timescale 1ns / 1ps

package spi_epw_pkg;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;

  // SPI EEPROM opcodes
  localparam logic [DATA_W-1:0] OP_WREN  = 8'h06;
  localparam logic [DATA_W-1:0] OP_WRITE = 8'h02;

  // Position within the byte sequence of one item
  typedef enum logic [2:0] {
    IDX_WREN,
    IDX_WRITE,
    IDX_ADDR_HI,
    IDX_ADDR_LO,
    IDX_DATA
  } seq_idx_t;

endpackage

// ----- hdl/spi_eeprom_page_write_sequencer_unit.sv -----
`timescale 1ns / 1ps
`include "spi_eeprom_page_write_sequencer_unit_defines.svh"

// Turns a stream of EEPROM write data bytes into the SPI byte stream with
// chip-select framing. A byte that opens a page frame (first byte of a
// transaction, no frame open, or an address on a PAGE_BYTES boundary)
// produces five transfers: WREN in a frame of its own, WRITE, address high,
// address low and the data byte; any other byte produces one transfer. The
// output register sends one SPI byte per cycle while out_tready is not
// holding it, and the next item is taken in the cycle its data byte moves
// to the output register. An input transfer is registered in the job stage
// and then in the output register before out_tvalid rises. Addresses wrap
// at 16 bits and the wrap counts as a page boundary. PAGE_BYTES may be any
// value from 2 to 4096; the page offset is found with a constant reciprocal
// multiply at the input and a constant multiply-subtract in the job stage.
module spi_eeprom_page_write_sequencer_unit
  import spi_epw_pkg::*;
#(
  parameter int PAGE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [15:0] start_address, [23:16] data_byte
  input  logic [23:0] in_tdata,
  // in_tuser: first_byte
  input  logic        in_tuser,
  // in_tlast: last_byte
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [7:0] spi_byte
  output logic [7:0]  out_tdata,
  // out_tuser: [0] select_before, [1] release_after
  output logic [1:0]  out_tuser,
  // out_tlast: last_of_run
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready
);

  // Reciprocal constants for the page offset (quotient may be low by one)
  localparam int PW     = $clog2(PAGE_BYTES + 1);
  localparam int SHIFT  = ADDR_W + $clog2(PAGE_BYTES);
  localparam int MULT_W = ADDR_W + 1;
  localparam logic [MULT_W-1:0] MULT = MULT_W'((64'd1 << SHIFT) / PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_LEN  = ADDR_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_LAST = ADDR_W'(PAGE_BYTES - 1);

  logic                     in_acc;
  logic [ADDR_W-1:0]        acc_addr;
  logic [ADDR_W+MULT_W-1:0] acc_prod;

  logic [ADDR_W-1:0] next_addr_r;
  logic              frame_open_r;

  logic              job_vld_r;
  logic [ADDR_W-1:0] job_addr_r;
  logic [ADDR_W-1:0] job_quo_r;
  logic [DATA_W-1:0] job_data_r;
  logic              job_first_r;
  logic              job_last_r;
  seq_idx_t          job_idx_r;
  seq_idx_t          job_idx_nxt;

  logic [ADDR_W+PW-1:0] qp;
  logic [ADDR_W-1:0]    rem_raw;
  logic [ADDR_W-1:0]    rem;
  logic                 start;
  logic                 release_frm;
  seq_idx_t             cur_idx;
  logic                 out_load;
  logic                 job_done;

  logic              out_vld_r;
  logic [DATA_W-1:0] out_byte_r;
  logic [DATA_W-1:0] out_byte_nxt;
  logic              out_sel_r;
  logic              out_sel_nxt;
  logic              out_rel_r;
  logic              out_rel_nxt;
  logic              out_last_r;
  logic              out_last_nxt;

  // Input side
  assign in_tready = !job_vld_r || job_done;
  assign in_acc    = in_tvalid && in_tready;
  assign acc_addr  = in_tuser ? in_tdata[ADDR_W-1:0] : next_addr_r;
  assign acc_prod  = acc_addr * MULT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_addr_r <= '0;
    end else if (in_acc) begin
      next_addr_r <= acc_addr + ADDR_W'(1);
    end
  end

  // Job register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else if (in_acc) begin
      job_vld_r <= 1'b1;
    end else if (job_done) begin
      job_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_addr_r  <= acc_addr;
      job_quo_r   <= ADDR_W'(acc_prod >> SHIFT);
      job_data_r  <= in_tdata[ADDR_W +: DATA_W];
      job_first_r <= in_tuser;
      job_last_r  <= in_tlast;
    end
  end

  // Page offset and framing decisions
  always_comb begin
    qp          = job_quo_r * PW'(PAGE_BYTES);
    rem_raw     = job_addr_r - qp[ADDR_W-1:0];
    rem         = (rem_raw >= PAGE_LEN) ? rem_raw - PAGE_LEN : rem_raw;
    start       = job_first_r || !frame_open_r || (rem == '0);
    release_frm = job_last_r || (rem == PAGE_LAST) || (job_addr_r == '1);
  end

  assign cur_idx  = (job_idx_r == IDX_WREN && !start) ? IDX_DATA : job_idx_r;
  assign out_load = job_vld_r && (!out_vld_r || out_tready);
  assign job_done = out_load && (cur_idx == IDX_DATA);

  // Sequence position register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_idx_r <= IDX_WREN;
    end else if (in_acc) begin
      job_idx_r <= IDX_WREN;
    end else if (out_load) begin
      job_idx_r <= job_idx_nxt;
    end
  end

  // Next position and the byte for the current one
  always_comb begin
    job_idx_nxt  = IDX_DATA;
    out_byte_nxt = job_data_r;
    out_sel_nxt  = 1'b0;
    out_rel_nxt  = 1'b0;
    out_last_nxt = 1'b0;
    unique case (cur_idx)
      IDX_WREN: begin
        job_idx_nxt  = IDX_WRITE;
        out_byte_nxt = OP_WREN;
        out_sel_nxt  = 1'b1;
        out_rel_nxt  = 1'b1;
      end
      IDX_WRITE: begin
        job_idx_nxt  = IDX_ADDR_HI;
        out_byte_nxt = OP_WRITE;
        out_sel_nxt  = 1'b1;
      end
      IDX_ADDR_HI: begin
        job_idx_nxt  = IDX_ADDR_LO;
        out_byte_nxt = job_addr_r[ADDR_W-1 -: DATA_W];
      end
      IDX_ADDR_LO: begin
        job_idx_nxt  = IDX_DATA;
        out_byte_nxt = job_addr_r[DATA_W-1:0];
      end
      IDX_DATA: begin
        job_idx_nxt  = IDX_DATA;
        out_byte_nxt = job_data_r;
        out_rel_nxt  = release_frm;
        out_last_nxt = 1'b1;
      end
      default: begin
        job_idx_nxt  = IDX_DATA;
      end
    endcase
  end

  // Frame state follows each data byte as it leaves the job stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
    end else if (job_done) begin
      frame_open_r <= !release_frm;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= out_byte_nxt;
      out_sel_r  <= out_sel_nxt;
      out_rel_r  <= out_rel_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_rel_r, out_sel_r};
  assign out_tlast  = out_last_r;

  // A new item enters only into an empty job stage or one whose data byte leaves
  `SEPW_ASSERT(a_accept_slot, clk, rst_n,
    in_acc |-> (!job_vld_r || (out_load && cur_idx == IDX_DATA)))
  // The data byte never opens a frame
  `SEPW_ASSERT(a_data_no_select, clk, rst_n, out_vld_r && out_last_r |-> !out_sel_r)
  // Sequence position holds while the output side is stalled
  `SEPW_ASSERT(a_idx_hold, clk, rst_n,
    job_vld_r && !out_load && !in_acc |=> job_idx_r == $past(job_idx_r))
  // Frame state after a data byte matches its release flag
  `SEPW_ASSERT(a_frame_track, clk, rst_n,
    job_done |=> frame_open_r == !$past(release_frm))
  // Output valid and job valid are low right after reset
  `SEPW_ASSERT_ALWAYS(a_reset_quiet, clk, !$past(rst_n) |-> !out_vld_r && !job_vld_r)

endmodule
